// ===== sv/crc16_framed_packet_receiver_macros.svh =====
// Assertion macros used by the framed packet receiver top level
`ifndef CRC16_FRAMED_PACKET_RECEIVER_MACROS_SVH
`define CRC16_FRAMED_PACKET_RECEIVER_MACROS_SVH

// antecedent holds -> consequent holds in the same cycle
`define CRCFPR_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// antecedent holds -> consequent holds in the next cycle
`define CRCFPR_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== sv/crcfpr_pkg.sv =====
// Types and constants of the framed packet receiver
package crcfpr_pkg;

  localparam int unsigned MAX_PAYLOAD  = 32;
  localparam int unsigned DETECT_LEN   = 12;
  localparam int unsigned SAMPLE_BYTES = 12;
  localparam int unsigned CFG_INDEX_W  = 2;

  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'hA001;
  localparam logic [7:0]  SYNC1    = 8'hAA;
  localparam logic [7:0]  SYNC2    = 8'h55;
  localparam logic [7:0]  HEARTBEAT_LEN = 8'd1;
  localparam logic [7:0]  STATUS_LEN    = 8'd2;

  localparam logic [CFG_INDEX_W-1:0] REG_PROTOCOL_VERSION = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_HEARTBEAT_TYPE   = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_DETECT_TYPE      = 2'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_STATUS_TYPE      = 2'd3;

  localparam logic [2:0] EV_DETECT    = 3'd0;
  localparam logic [2:0] EV_HEARTBEAT = 3'd1;
  localparam logic [2:0] EV_STATUS    = 3'd2;
  localparam logic [2:0] EV_CRC       = 3'd3;
  localparam logic [2:0] EV_VERSION   = 3'd4;
  localparam logic [2:0] EV_TYPE      = 3'd5;
  localparam logic [2:0] EV_LENGTH    = 3'd6;

  typedef struct packed {
    logic [7:0] protocol_version;
    logic [7:0] heartbeat_type;
    logic [7:0] detect_type;
    logic [7:0] status_type;
  } cfg_t;

  typedef logic [SAMPLE_BYTES-1:0][7:0] sample_t;

  typedef struct packed {
    logic [2:0]         event_kind;
    logic [7:0]         frame_sequence;
    logic [7:0]         sequence_gap;
    logic signed [15:0] position_tenths_cm;
    logic signed [15:0] velocity_tenths_cm_s;
    logic [15:0]        source_time_ms;
    logic [7:0]         stable_flag;
    logic [7:0]         confidence_level;
    logic [15:0]        pixel_x;
    logic [15:0]        pixel_y;
    logic               sample_valid;
  } event_t;

endpackage

// ===== sv/crcfpr_cfg_regs.sv =====
// Configuration register bank of the framed packet receiver
module crcfpr_cfg_regs (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [crcfpr_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [7:0]                         cfg_data,
  output crcfpr_pkg::cfg_t                   cfg
);
  import crcfpr_pkg::*;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.protocol_version <= 8'd1;
      cfg.heartbeat_type   <= 8'd1;
      cfg.detect_type      <= 8'd2;
      cfg.status_type      <= 8'd3;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_PROTOCOL_VERSION: cfg.protocol_version <= cfg_data;
        REG_HEARTBEAT_TYPE:   cfg.heartbeat_type   <= cfg_data;
        REG_DETECT_TYPE:      cfg.detect_type      <= cfg_data;
        REG_STATUS_TYPE:      cfg.status_type      <= cfg_data;
        default: ;
      endcase
    end
  end

endmodule

// ===== sv/crcfpr_parser.sv =====
// Frame parser: sync hunt, header checks, payload capture, CRC-16/MODBUS and events
module crcfpr_parser (
  input  logic               clk,
  input  logic               rst,
  input  logic               fire,
  input  logic [7:0]         rx_byte,
  input  crcfpr_pkg::cfg_t   cfg,
  output logic               ev_valid,
  output crcfpr_pkg::event_t ev
);
  import crcfpr_pkg::*;

  localparam logic [3:0] PH_SYNC1   = 4'd0;
  localparam logic [3:0] PH_SYNC2   = 4'd1;
  localparam logic [3:0] PH_VERSION = 4'd2;
  localparam logic [3:0] PH_TYPE    = 4'd3;
  localparam logic [3:0] PH_SEQ     = 4'd4;
  localparam logic [3:0] PH_LENGTH  = 4'd5;
  localparam logic [3:0] PH_PAYLOAD = 4'd6;
  localparam logic [3:0] PH_CRC_LO  = 4'd7;
  localparam logic [3:0] PH_CRC_HI  = 4'd8;

  localparam logic [1:0] CLS_DETECT    = 2'd0;
  localparam logic [1:0] CLS_HEARTBEAT = 2'd1;
  localparam logic [1:0] CLS_STATUS    = 2'd2;
  localparam logic [1:0] CLS_AMBIGUOUS = 2'd3;

  localparam logic [7:0] MAX_LEN   = 8'(MAX_PAYLOAD);
  localparam logic [7:0] DET_LEN   = 8'(DETECT_LEN);
  localparam logic [7:0] STORE_LEN = 8'(SAMPLE_BYTES);

  function automatic logic [15:0] crc_byte(input logic [15:0] c, input logic [7:0] b);
    logic [15:0] r;
    r = c ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      r = r[0] ? ((r >> 1) ^ CRC_POLY) : (r >> 1);
    end
    return r;
  endfunction

  function automatic event_t put_sample(input event_t e, input sample_t s);
    event_t r;
    r = e;
    r.position_tenths_cm   = {s[1], s[0]};
    r.velocity_tenths_cm_s = {s[3], s[2]};
    r.source_time_ms       = {s[5], s[4]};
    r.stable_flag          = s[6];
    r.confidence_level     = s[7];
    r.pixel_x              = {s[9], s[8]};
    r.pixel_y              = {s[11], s[10]};
    return r;
  endfunction

  logic [3:0]  phase, phase_next;
  logic [15:0] crc, crc_next;
  logic [7:0]  crc_lo, crc_lo_next;
  logic [1:0]  frame_class, frame_class_next;
  logic [7:0]  frame_seq, frame_seq_next;
  logic [7:0]  exp_len, exp_len_next;
  logic [7:0]  count, count_next;
  logic [7:0]  last_seq, last_seq_next;
  logic        seen_seq, seen_seq_next;
  sample_t     payload_store;
  sample_t     stored_sample;
  logic        store_we;
  logic        sample_we;
  logic        restart;
  logic [15:0] crc_upd;
  logic [15:0] crc_sync;
  logic [7:0]  gap;
  logic [1:0]  hits;
  logic        len_bad;

  assign crc_upd  = crc_byte(crc, rx_byte);
  assign crc_sync = crc_byte(CRC_INIT, rx_byte);
  assign gap      = seen_seq ? (frame_seq - (last_seq + 8'd1)) : 8'd0;
  assign hits     = 2'(rx_byte == cfg.heartbeat_type) + 2'(rx_byte == cfg.detect_type)
                  + 2'(rx_byte == cfg.status_type);
  assign len_bad  = (rx_byte > MAX_LEN)
                 || (frame_class == CLS_AMBIGUOUS)
                 || (frame_class == CLS_HEARTBEAT && rx_byte != HEARTBEAT_LEN)
                 || (frame_class == CLS_DETECT && rx_byte != DET_LEN)
                 || (frame_class == CLS_STATUS && rx_byte != STATUS_LEN);

  always_comb begin
    phase_next       = phase;
    crc_next         = crc;
    crc_lo_next      = crc_lo;
    frame_class_next = frame_class;
    frame_seq_next   = frame_seq;
    exp_len_next     = exp_len;
    count_next       = count;
    last_seq_next    = last_seq;
    seen_seq_next    = seen_seq;
    store_we         = 1'b0;
    sample_we        = 1'b0;
    restart          = 1'b0;
    ev_valid         = 1'b0;
    ev               = '0;
    case (phase)
      PH_SYNC2: begin
        if (rx_byte == SYNC2) begin
          crc_next   = crc_upd;
          phase_next = PH_VERSION;
        end else if (rx_byte == SYNC1) begin
          crc_next = crc_sync;
        end else begin
          restart = 1'b1;
        end
      end
      PH_VERSION: begin
        if (rx_byte != cfg.protocol_version) begin
          restart       = 1'b1;
          ev_valid      = 1'b1;
          ev.event_kind = EV_VERSION;
        end else begin
          crc_next   = crc_upd;
          phase_next = PH_TYPE;
        end
      end
      PH_TYPE: begin
        if (hits == 2'd0) begin
          restart       = 1'b1;
          ev_valid      = 1'b1;
          ev.event_kind = EV_TYPE;
        end else begin
          if (hits > 2'd1) begin
            frame_class_next = CLS_AMBIGUOUS;
          end else if (rx_byte == cfg.detect_type) begin
            frame_class_next = CLS_DETECT;
          end else if (rx_byte == cfg.heartbeat_type) begin
            frame_class_next = CLS_HEARTBEAT;
          end else begin
            frame_class_next = CLS_STATUS;
          end
          crc_next   = crc_upd;
          phase_next = PH_SEQ;
        end
      end
      PH_SEQ: begin
        frame_seq_next = rx_byte;
        crc_next       = crc_upd;
        phase_next     = PH_LENGTH;
      end
      PH_LENGTH: begin
        if (len_bad) begin
          restart       = 1'b1;
          ev_valid      = 1'b1;
          ev.event_kind = EV_LENGTH;
        end else begin
          exp_len_next = rx_byte;
          count_next   = 8'd0;
          crc_next     = crc_upd;
          phase_next   = (rx_byte == 8'd0) ? PH_CRC_LO : PH_PAYLOAD;
        end
      end
      PH_PAYLOAD: begin
        store_we   = (count < STORE_LEN);
        crc_next   = crc_upd;
        count_next = count + 8'd1;
        if (count_next >= exp_len) begin
          phase_next = PH_CRC_LO;
        end
      end
      PH_CRC_LO: begin
        crc_lo_next = rx_byte;
        phase_next  = PH_CRC_HI;
      end
      PH_CRC_HI: begin
        restart  = 1'b1;
        ev_valid = 1'b1;
        if ({rx_byte, crc_lo} != crc) begin
          ev.event_kind = EV_CRC;
        end else begin
          last_seq_next     = frame_seq;
          seen_seq_next     = 1'b1;
          ev.frame_sequence = frame_seq;
          ev.sequence_gap   = gap;
          case (frame_class)
            CLS_DETECT: begin
              sample_we       = 1'b1;
              ev              = put_sample(ev, payload_store);
              ev.event_kind   = EV_DETECT;
              ev.sample_valid = 1'b1;
            end
            CLS_HEARTBEAT: begin
              ev.event_kind = EV_HEARTBEAT;
            end
            default: begin
              ev            = put_sample(ev, stored_sample);
              ev.event_kind = EV_STATUS;
            end
          endcase
        end
      end
      default: begin
        phase_next   = (rx_byte == SYNC1) ? PH_SYNC2 : PH_SYNC1;
        crc_next     = (rx_byte == SYNC1) ? crc_sync : CRC_INIT;
        crc_lo_next  = 8'd0;
        exp_len_next = 8'd0;
        count_next   = 8'd0;
      end
    endcase
    if (restart) begin
      phase_next   = PH_SYNC1;
      crc_next     = CRC_INIT;
      crc_lo_next  = 8'd0;
      exp_len_next = 8'd0;
      count_next   = 8'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_SYNC1;
      crc           <= CRC_INIT;
      crc_lo        <= 8'd0;
      frame_class   <= CLS_DETECT;
      frame_seq     <= 8'd0;
      exp_len       <= 8'd0;
      count         <= 8'd0;
      last_seq      <= 8'd0;
      seen_seq      <= 1'b0;
      stored_sample <= '0;
    end else if (fire) begin
      phase       <= phase_next;
      crc         <= crc_next;
      crc_lo      <= crc_lo_next;
      frame_class <= frame_class_next;
      frame_seq   <= frame_seq_next;
      exp_len     <= exp_len_next;
      count       <= count_next;
      last_seq    <= last_seq_next;
      seen_seq    <= seen_seq_next;
      if (sample_we) begin
        stored_sample <= payload_store;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fire && store_we) begin
      payload_store[count[3:0]] <= rx_byte;
    end
  end

endmodule

// ===== sv/crc16_framed_packet_receiver.sv =====
// Top level of the framed packet receiver: input register, parser and event register
//
//  channel | signals                                 | direction
//  --------+-----------------------------------------+----------
//  byte    | byte_valid, byte_stall, rx_byte         | in
//  event   | event_valid, event_stall, event fields  | out
//  config  | cfg_valid, cfg_ready, cfg_index, cfg_data | in
//
// One byte per cycle while no event is stalled; a taken byte waits in the input register.
// The whole parse of a byte sits between the input register and the event register.
// Synchronous reset restores the register defaults and the sync hunt.
// A stalled event holds the parser; the input register takes one more request.
module crc16_framed_packet_receiver (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               byte_valid,
  output logic                               byte_stall,
  input  logic [7:0]                         rx_byte,
  output logic                               event_valid,
  input  logic                               event_stall,
  output logic [2:0]                         event_kind,
  output logic [7:0]                         frame_sequence,
  output logic [7:0]                         sequence_gap,
  output logic signed [15:0]                 position_tenths_cm,
  output logic signed [15:0]                 velocity_tenths_cm_s,
  output logic [15:0]                        source_time_ms,
  output logic [7:0]                         stable_flag,
  output logic [7:0]                         confidence_level,
  output logic [15:0]                        pixel_x,
  output logic [15:0]                        pixel_y,
  output logic                               sample_valid,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [crcfpr_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [7:0]                         cfg_data
);
  import crcfpr_pkg::*;
  `include "crc16_framed_packet_receiver_macros.svh"

  cfg_t       cfg;
  logic       in_held;
  logic [7:0] in_byte;
  logic       advance;
  logic       fire;
  logic       ev_valid;
  event_t     ev;
  event_t     ev_reg;

  assign advance    = !(event_valid && event_stall);
  assign fire       = in_held && advance;
  assign byte_stall = in_held && !advance;

  crcfpr_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  crcfpr_parser u_parser (
    .clk      (clk),
    .rst      (rst),
    .fire     (fire),
    .rx_byte  (in_byte),
    .cfg      (cfg),
    .ev_valid (ev_valid),
    .ev       (ev)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      in_held <= 1'b0;
    end else if (byte_valid && !byte_stall) begin
      in_held <= 1'b1;
    end else if (fire) begin
      in_held <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (byte_valid && !byte_stall) begin
      in_byte <= rx_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      event_valid <= 1'b0;
    end else if (advance) begin
      event_valid <= fire && ev_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      ev_reg <= ev;
    end
  end

  assign event_kind           = ev_reg.event_kind;
  assign frame_sequence       = ev_reg.frame_sequence;
  assign sequence_gap         = ev_reg.sequence_gap;
  assign position_tenths_cm   = ev_reg.position_tenths_cm;
  assign velocity_tenths_cm_s = ev_reg.velocity_tenths_cm_s;
  assign source_time_ms       = ev_reg.source_time_ms;
  assign stable_flag          = ev_reg.stable_flag;
  assign confidence_level     = ev_reg.confidence_level;
  assign pixel_x              = ev_reg.pixel_x;
  assign pixel_y              = ev_reg.pixel_y;
  assign sample_valid         = ev_reg.sample_valid;

  `CRCFPR_ASSERT_IMP(a_hold_on_stall, clk, rst, event_valid && event_stall, !fire, "parser advanced under a stalled event")
  `CRCFPR_ASSERT_IMP(a_sample_only_detect, clk, rst, event_valid && sample_valid, event_kind == EV_DETECT, "sample marked valid on a non-detect event")
  `CRCFPR_ASSERT_IMP(a_error_no_seq, clk, rst, event_valid && (event_kind == EV_CRC || event_kind == EV_VERSION || event_kind == EV_TYPE || event_kind == EV_LENGTH), frame_sequence == 8'd0 && sequence_gap == 8'd0, "error event carries sequence data")
  `CRCFPR_ASSERT_NEXT(a_fire_drains, clk, rst, fire && !(byte_valid && !byte_stall), !in_held, "input register kept a consumed byte")

endmodule
